@@ src/tkfr_pkg.sv @@
// ----------------------------------------------------------------------------
// tkfr_pkg
// Shared field widths and the result item type of the top-k frequency
// recommender.
// ----------------------------------------------------------------------------
package tkfr_pkg;

  localparam int ID_W        = 16;  // item, query and recommended ids
  localparam int RANK_W      = 4;   // reported rank
  localparam int LIM_W       = 4;   // list_limit register
  localparam int OUT_TDATA_W = 40;  // query_id + rec_id + rank, padded to bytes

  // One result item as held in the output buffer
  typedef struct packed {
    logic              last;
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   rec_id;
    logic [ID_W-1:0]   query_id;
  } tkfr_res_t;

endpackage

@@ src/tkfr_out_buf.sv @@
// ----------------------------------------------------------------------------
// tkfr_out_buf
// Two-entry output buffer (head register plus skid register) that decouples
// the result stream from the list memory read pipeline.
// ----------------------------------------------------------------------------
module tkfr_out_buf import tkfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tkfr_res_t push_data,
  input  logic      pop,
  output logic      head_vld,
  output tkfr_res_t head_data,
  output logic [1:0] level
);

  logic      head_v_r, head_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  tkfr_res_t head_r, head_nxt;
  tkfr_res_t skid_r, skid_nxt;

  // head / skid update
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign head_vld  = head_v_r;
  assign head_data = head_r;
  assign level     = {1'b0, head_v_r} + {1'b0, skid_v_r};

endmodule

@@ src/top_k_frequency_recommender.sv @@
// Result path: the count memory read is registered and incremented in S_CNT, the list
//   memory is read in S_SCAN, and each result is registered in the output buffer.
// Items: in_tready is high only in S_IDLE, so one item runs at a time; one list read
//   per cycle, for the report/membership scan while the output buffer has room and
//   then for the bubble pass. Reset: synchronous, active low; afterwards a clearing
//   pass writes zero to all ID_SPACE count entries with in_tready low.
// ----------------------------------------------------------------------------
// top_k_frequency_recommender
// Counts queried item ids in a count memory and keeps a ranked list of the
// most frequent ids in a small list memory; reports the list on every accepted query but the first.
// ----------------------------------------------------------------------------
module top_k_frequency_recommender import tkfr_pkg::*; #(
  parameter int ID_SPACE   = 65536,
  parameter int MAX_LIST   = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ID_W-1:0]        in_tdata,   // [15:0] item_id
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] query_id, [31:16] rec_id,
                                             // [35:32] rank, [39:36] zero
  output logic                   out_tlast,  // last
  // configuration
  input  logic                   cfg_wen,
  input  logic [LIM_W-1:0]       cfg_wdata   // list_limit
);

  localparam int IW      = $clog2(ID_SPACE);
  localparam int LW      = $clog2(MAX_LIST + 1);
  localparam int XW      = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int EW      = ID_W + COUNT_BITS;
  localparam int LIM_RST = (MAX_LIST < 10) ? MAX_LIST : 10;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_BUB   = 3'd5;

  // true when entry a ranks strictly ahead of entry b
  function automatic logic ahead(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [COUNT_BITS-1:0] ca;
    logic [COUNT_BITS-1:0] cb;
    ca = a[COUNT_BITS-1:0];
    cb = b[COUNT_BITS-1:0];
    return (ca > cb) || ((ca == cb) && (a[EW-1:COUNT_BITS] < b[EW-1:COUNT_BITS]));
  endfunction

  // control and payload registers
  logic [2:0]            state_r, state_nxt;
  logic [IW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  seen_r, seen_nxt;
  logic [LW-1:0]         limit_r, limit_nxt;
  logic [LW-1:0]         size_r, size_nxt;
  logic [LW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [LW-1:0]         pos_r, pos_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic                  emit_r, emit_nxt;
  logic                  member_r, member_nxt;
  logic [COUNT_BITS-1:0] newcnt_r, newcnt_nxt;
  logic [EW-1:0]         tail_r, tail_nxt;
  logic [EW-1:0]         carry_r, carry_nxt;

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [ID_SPACE];
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic                  cnt_re, cnt_we;
  logic [IW-1:0]         cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_inc;

  logic [EW-1:0]         lst_mem [MAX_LIST];
  logic [EW-1:0]         lst_rd_r;
  logic                  lst_re, lst_we;
  logic [XW-1:0]         lst_raddr, lst_waddr;
  logic [EW-1:0]         lst_wdata;

  // misc
  logic                  in_acc, id_ok, pop, scan_push, scan_issue, bub_issue, last_pos;
  logic [2:0]            lvl_after;
  logic [1:0]            buf_level;
  logic [LW-1:0]         idx_m1, size_upd;
  logic [ID_W-1:0]       rd_id;
  logic [EW-1:0]         rd_ent, new_ent, carry_upd;
  logic [7:0]            cfg_v8, cfg_lim8;
  logic [LW-1:0]         cfg_lim;
  tkfr_res_t             push_data, head_data;

  // input qualification
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign id_ok     = (in_tdata != '0) && ({16'd0, in_tdata} < 32'(ID_SPACE));

  // count memory ports
  assign cnt_re    = in_acc & id_ok;
  assign cnt_raddr = IW'({16'd0, in_tdata});
  assign cnt_inc   = (cnt_rd_r == {COUNT_BITS{1'b1}}) ? cnt_rd_r
                                                      : cnt_rd_r + COUNT_BITS'(1);
  assign cnt_we    = (state_r == S_CLEAR) || (state_r == S_CNT);
  assign cnt_waddr = (state_r == S_CLEAR) ? clr_addr_r : IW'({16'd0, id_r});
  assign cnt_wdata = (state_r == S_CLEAR) ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  // list read data, with the queried id's fresh count forwarded
  assign rd_id    = lst_rd_r[EW-1:COUNT_BITS];
  assign rd_ent   = (rd_id == id_r) ? {rd_id, newcnt_r} : lst_rd_r;
  assign new_ent  = {id_r, newcnt_r};
  assign last_pos = ((pos_r + LW'(1)) == size_r);
  assign idx_m1   = idx_r - LW'(1);

  // scan issues a read only when a slot is sure to be free for its result
  assign pop        = out_tvalid & out_tready;
  assign scan_push  = (state_r == S_SCAN) & pend_r & emit_r;
  assign lvl_after  = 3'(buf_level) + 3'(scan_push) - 3'(pop);
  assign scan_issue = (state_r == S_SCAN) && (idx_r < size_r) &&
                      (!emit_r || (lvl_after <= 3'd1));
  assign bub_issue  = (state_r == S_BUB) && (idx_r != '0);

  assign lst_re    = scan_issue | bub_issue;
  assign lst_raddr = scan_issue ? idx_r[XW-1:0] : idx_m1[XW-1:0];

  always_ff @(posedge clk) begin
    if (lst_we) lst_mem[lst_waddr] <= lst_wdata;
    if (lst_re) lst_rd_r <= lst_mem[lst_raddr];
  end

  // result item
  always_comb begin
    push_data.query_id = id_r;
    push_data.rec_id   = rd_id;
    push_data.rank     = RANK_W'(pos_r);
    push_data.last     = last_pos;
  end

  // list update decision for the queried id
  always_comb begin
    size_upd  = size_r;
    carry_upd = tail_r;
    if (member_r) begin
      carry_upd = tail_r;
    end else if (size_r < limit_r) begin
      carry_upd = new_ent;
      size_upd  = size_r + LW'(1);
    end else if ((size_r != '0) && ahead(new_ent, tail_r)) begin
      carry_upd = new_ent;
    end
  end

  // configuration clamp
  assign cfg_v8   = {4'd0, cfg_wdata};
  assign cfg_lim8 = (cfg_v8 == 8'd0)          ? 8'd1 :
                    (cfg_v8 > 8'(MAX_LIST))   ? 8'(MAX_LIST) : cfg_v8;
  assign cfg_lim  = LW'(cfg_lim8);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    seen_nxt     = seen_r;
    limit_nxt    = limit_r;
    size_nxt     = size_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pos_nxt      = pos_r;
    id_nxt       = id_r;
    emit_nxt     = emit_r;
    member_nxt   = member_r;
    newcnt_nxt   = newcnt_r;
    tail_nxt     = tail_r;
    carry_nxt    = carry_r;
    lst_we       = 1'b0;
    lst_waddr    = pos_r[XW-1:0];
    lst_wdata    = carry_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + IW'(1);
        if (clr_addr_r == IW'(ID_SPACE - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && id_ok) begin
          id_nxt    = in_tdata;
          emit_nxt  = seen_r;
          seen_nxt  = 1'b1;
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        newcnt_nxt = cnt_inc;
        idx_nxt    = '0;
        pend_nxt   = 1'b0;
        member_nxt = 1'b0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        // report the list and look for the queried id
        pend_nxt = scan_issue;
        if (scan_issue) begin
          idx_nxt = idx_r + LW'(1);
          pos_nxt = idx_r;
        end
        if (pend_r) begin
          if (rd_id == id_r) member_nxt = 1'b1;
          if (last_pos) tail_nxt = rd_ent;
        end
        if (!pend_r && (idx_r == size_r)) state_nxt = S_UPD;
      end
      S_UPD: begin
        size_nxt  = size_upd;
        carry_nxt = carry_upd;
        idx_nxt   = size_upd - LW'(1);
        pend_nxt  = 1'b0;
        state_nxt = S_BUB;
      end
      S_BUB: begin
        // one bubble pass, tail to head, carrying the rising entry
        pend_nxt = bub_issue;
        if (bub_issue) begin
          idx_nxt = idx_m1;
          pos_nxt = idx_r;
        end
        if (pend_r) begin
          lst_we    = 1'b1;
          lst_waddr = pos_r[XW-1:0];
          if (ahead(carry_r, rd_ent)) begin
            lst_wdata = rd_ent;
          end else begin
            lst_wdata = carry_r;
            carry_nxt = rd_ent;
          end
        end else if (idx_r == '0) begin
          lst_we    = 1'b1;
          lst_waddr = '0;
          lst_wdata = carry_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wen) begin
      limit_nxt = cfg_lim;
      if (size_r > cfg_lim) size_nxt = cfg_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      seen_r     <= 1'b0;
      limit_r    <= LW'(LIM_RST);
      size_r     <= '0;
      idx_r      <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      seen_r     <= seen_nxt;
      limit_r    <= limit_nxt;
      size_r     <= size_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
    end
    pos_r    <= pos_nxt;
    id_r     <= id_nxt;
    emit_r   <= emit_nxt;
    member_r <= member_nxt;
    newcnt_r <= newcnt_nxt;
    tail_r   <= tail_nxt;
    carry_r  <= carry_nxt;
  end

  // output buffer
  tkfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (scan_push),
    .push_data (push_data),
    .pop       (pop),
    .head_vld  (out_tvalid),
    .head_data (head_data),
    .level     (buf_level)
  );

  assign out_tdata = {{(OUT_TDATA_W - RANK_W - 2 * ID_W){1'b0}},
                      head_data.rank, head_data.rec_id, head_data.query_id};
  assign out_tlast = head_data.last;

`ifndef SYNTHESIS
  // list never holds more than the limit
  a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= limit_r)
    else $error("list size above limit");

  // scan credit keeps the output buffer from overflowing
  a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
    scan_push |-> ((buf_level != 2'd2) || pop))
    else $error("output buffer overflow");

  // update starts only after the scan has fully drained
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (!pend_r && (idx_r == size_r)))
    else $error("update entered with scan in flight");
`endif

endmodule

@@ tb/sv/top_k_frequency_recommender_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequency_recommender_tb
// Streams queried item ids into the recommender and checks every reported
// ranked-list entry against a behavioral tracker of hit counts and top list.
// Covers ignored zero ids, the silent first query, list fill and tail
// replacement, limit clamping and cutting, output back-pressure, random
// query mixes under several limits and equal-count tie ordering.
// ----------------------------------------------------------------------------
module top_k_frequency_recommender_tb;
  import tkfr_pkg::*;

  localparam int          TOP_MAX      = 10;         // list depth of the block
  localparam logic [15:0] HIT_CEIL     = 16'hFFFF;   // saturated hit count
  localparam int          SETTLE       = 40;         // cycles past last result
  localparam int          LONG_HOLD    = 400;        // receiver hold-off
  localparam int          LIMIT_CYCLES = 5_000_000;  // run watchdog

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ID_W-1:0]        in_tdata;   // [15:0] item_id
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] query_id, [31:16] rec_id, [35:32] rank
  logic                   out_tlast;  // last
  logic                   cfg_wen;
  logic [LIM_W-1:0]       cfg_wdata;  // list_limit

  // tracker state
  logic [15:0]     hit_tab [0:65535];
  logic [ID_W-1:0] top_ids [0:TOP_MAX-1];
  int unsigned     top_len;
  int unsigned     top_limit;
  bit              any_query_seen;
  tkfr_res_t       recs_due [$];

  // stimulus controls
  bit              tx_idle;
  bit              rx_idle;
  int unsigned     hold_req  = 0;   // long hold-offs requested by the tests
  int unsigned     hold_done = 0;   // long hold-offs served by the receiver
  logic [ID_W-1:0] id_pool [$];

  int unsigned     mismatches = 0;
  int unsigned     cycle_cnt  = 0;
  tkfr_res_t       got_rec;
  tkfr_res_t       want_rec;

  top_k_frequency_recommender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("top_k_frequency_recommender_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tracker
  function automatic bit outranks(input logic [15:0] a, input logic [15:0] b);
    return (hit_tab[a] > hit_tab[b]) || (hit_tab[a] == hit_tab[b] && a < b);
  endfunction

  // report the current list for this query, then count it and reorder
  task automatic rank_query(input logic [ID_W-1:0] id);
    tkfr_res_t   r;
    bit          member;
    logic [15:0] t;
    int          i;
    if (id == '0) return;
    if (any_query_seen) begin
      for (i = 0; i < top_len; i++) begin
        r.query_id = id;
        r.rec_id   = top_ids[i];
        r.rank     = i[RANK_W-1:0];
        r.last     = (i + 1 == top_len);
        recs_due.push_back(r);
      end
    end
    any_query_seen = 1'b1;
    if (hit_tab[id] != HIT_CEIL) hit_tab[id] = hit_tab[id] + 1'b1;
    member = 1'b0;
    for (i = 0; i < top_len; i++)
      if (top_ids[i] == id) member = 1'b1;
    if (!member) begin
      if (top_len < top_limit) begin
        top_ids[top_len] = id;
        top_len++;
      end else if (top_len > 0 && outranks(id, top_ids[top_len-1])) begin
        top_ids[top_len-1] = id;
      end
    end
    // one bubble pass, tail toward head
    for (i = top_len; i >= 2; i--) begin
      if (outranks(top_ids[i-1], top_ids[i-2])) begin
        t            = top_ids[i-1];
        top_ids[i-1] = top_ids[i-2];
        top_ids[i-2] = t;
      end
    end
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rec = tkfr_res_t'({out_tlast, out_tdata[35:0]});
      if (recs_due.size() == 0) begin
        $error("unexpected result: query_id %0d rec_id %0d rank %0d last %0d",
               got_rec.query_id, got_rec.rec_id, got_rec.rank, got_rec.last);
        mismatches++;
      end else begin
        want_rec = recs_due.pop_front();
        if (got_rec.query_id !== want_rec.query_id) begin
          $error("query_id: expected %0d, actual %0d", want_rec.query_id, got_rec.query_id);
          mismatches++;
        end
        if (got_rec.rec_id !== want_rec.rec_id) begin
          $error("rec_id: expected %0d, actual %0d", want_rec.rec_id, got_rec.rec_id);
          mismatches++;
        end
        if (got_rec.rank !== want_rec.rank) begin
          $error("rank: expected %0d, actual %0d", want_rec.rank, got_rec.rank);
          mismatches++;
        end
        if (got_rec.last !== want_rec.last) begin
          $error("last: expected %0d, actual %0d", want_rec.last, got_rec.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = hold_req;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_item(input logic [ID_W-1:0] id);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rank_query(id);
  endtask

  // stop offering, let all results drain and the block finish its pass
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (recs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIM_W-1:0] v);
    wait_quiet();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    top_limit = (v == 0) ? 1 : (v > TOP_MAX) ? TOP_MAX : v;
    if (top_len > top_limit) top_len = top_limit;
  endtask

  // skewed pick from the phase pool, with some wide-range and zero ids
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    int unsigned a;
    int unsigned b;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 13) return ID_W'($urandom_range(1, 65535));
    a = $urandom_range(0, id_pool.size() - 1);
    b = $urandom_range(0, id_pool.size() - 1);
    return id_pool[(a < b) ? a : b];
  endfunction

  // ---------------------------------------------------------------- tests
  // zero ids are dropped, first real query reports nothing, reset limit
  task automatic test_first_query();
    send_item(16'd0);
    send_item(16'hFFFF);
    send_item(16'd0);
    send_item(16'd1);
    send_item(16'd1);
    send_item(16'hFFFF);
  endtask

  // fill past the limit so the tail gets replaced
  task automatic test_list_fill();
    int i;
    set_limit(4'd15);
    for (i = 0; i < 12; i++) send_item(16'd100 + i[15:0]);
    send_item(16'd111);
    send_item(16'd105);
  endtask

  // lowering the limit cuts the list; zero acts as one
  task automatic test_limit_cut();
    set_limit(4'd3);
    send_item(16'd104);
    send_item(16'd1);
    set_limit(4'd0);
    send_item(16'h8000);
    send_item(16'd1);
  endtask

  task automatic test_random_mix();
    int p;
    int i;
    int n;
    for (p = 0; p < 6; p++) begin
      set_limit(LIM_W'($urandom_range(0, 15)));
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      id_pool.delete();
      n = $urandom_range(4, 14);
      for (i = 0; i < n; i++) id_pool.push_back(ID_W'($urandom_range(1, 65535)));
      for (i = 0; i < 24; i++) send_item(pick_id());
    end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
  endtask

  // receiver holds off while queries keep coming, input must stall
  task automatic test_backpressure();
    int i;
    set_limit(4'd10);
    hold_req = hold_req + 1;
    for (i = 0; i < 20; i++) send_item(ID_W'($urandom_range(1, 65535)));
  endtask

  // two ids with equal counts; ties go to the smaller id
  task automatic test_tie_order();
    logic [15:0] id_hi;
    logic [15:0] id_lo;
    id_hi = 16'hC35A;
    id_lo = 16'h00A5;
    set_limit(4'd1);
    send_item(id_hi);
    send_item(id_lo);
    send_item(id_hi);
    send_item(id_lo);
    send_item(id_hi);
    set_limit(4'd2);
    send_item(id_lo);
    send_item(id_hi);
    send_item(id_lo);
    send_item(id_hi);
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    for (int k = 0; k < 65536; k++) hit_tab[k] = '0;
    for (int k = 0; k < TOP_MAX; k++) top_ids[k] = '0;
    top_len        = 0;
    top_limit      = TOP_MAX;
    any_query_seen = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_first_query();
    test_list_fill();
    test_limit_cut();
    test_random_mix();
    test_backpressure();
    test_tie_order();
    wait_quiet();

    if (mismatches == 0)
      $display("top_k_frequency_recommender_tb: PASS");
    else
      $display("top_k_frequency_recommender_tb: FAIL");
    $finish;
  end

endmodule

@@ top_k_frequency_recommender.f @@
src/tkfr_pkg.sv
src/tkfr_out_buf.sv
src/top_k_frequency_recommender.sv
tb/sv/top_k_frequency_recommender_tb.sv
